// File: hw/rtl/dst_pkg.sv
// shared types and constants of the descriptor slot table
package dst_pkg;

  localparam int OPCODE_W   = 4;
  localparam int SLOT_W     = 16;
  localparam int HANDLE_W   = 16;
  localparam int SLOT_OUT_W = 6;
  localparam int STATUS_W   = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_LOWEST   = 4'd0,
    OP_INS_AT       = 4'd1,
    OP_REMOVE       = 4'd2,
    OP_LOOKUP       = 4'd3,
    OP_REMOVE_RANGE = 4'd4,
    OP_MARK_RANGE   = 4'd5,
    OP_MARK         = 4'd6,
    OP_UNMARK       = 4'd7,
    OP_TEST         = 4'd8,
    OP_EXEC_CLOSE   = 4'd9
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIND,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic [HANDLE_W-1:0]   handle_out;
    logic                  handle_valid;
    logic                  released;
    logic                  mark_out;
    logic                  last;
  } res_t;

endpackage

// File: hw/rtl/dst_req_if.sv
// request channel: one operation word per handshake
interface dst_req_if;
  import dst_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   slot_high;
  logic [HANDLE_W-1:0] handle;
  logic                close_on_exec;

  modport source (output valid, opcode, slot, slot_high, handle, close_on_exec,
                  input ready);
  modport sink (input valid, opcode, slot, slot_high, handle, close_on_exec,
                output ready);
endinterface

// File: hw/rtl/dst_rsp_if.sv
// response channel: one result word per handshake
interface dst_rsp_if;
  import dst_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot_out;
  logic [HANDLE_W-1:0]   handle_out;
  logic                  handle_valid;
  logic                  released;
  logic                  mark_out;
  logic                  last;

  modport source (output valid, status, slot_out, handle_out, handle_valid,
                  released, mark_out, last, input ready);
  modport sink (input valid, status, slot_out, handle_out, handle_valid,
                released, mark_out, last, output ready);
endinterface

// File: hw/rtl/dst_handle_ram.sv
// handle store: one write port, one read port with registered data
module dst_handle_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port with registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/descriptor_slot_table_core.sv
// descriptor slot table: handle store, valid and close-on-exec bits, sequencer
//
// Usage:
//   req carries one operation word (opcode, slot, slot_high, handle,
//   close_on_exec); rsp returns one or more result words, the final one with
//   last set. Range removal and exec-close return one word per released
//   handle in rising slot order, or a single empty word when none is released.
//   Items are handled one at a time: req.ready is high only while the
//   sequencer is idle. Mark, unmark, test and mark-range pass decode and emit;
//   single-slot reads (insert-at, remove, lookup) pass decode, read and emit,
//   or decode and emit if rejected; insert-lowest passes decode, find and
//   emit; a walk passes decode, then find, read and emit per released handle,
//   or find and emit if none is released. The cost is set by the handle RAM
//   read and by the find-first pass over the pending slot mask, one slot per
//   step. A result sits in an output register; the next item is accepted while
//   it waits, and the sequencer holds in its emit state only when a further
//   result is ready and the register is still full (rsp.ready low).
//   Reset clears the valid and mark bits and the control state; handle RAM
//   contents are don't-care until written and need no clearing pass.
module descriptor_slot_table_core #(
  parameter int SLOTS       = 64,
  parameter int HANDLE_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  dst_req_if.sink   req,
  dst_rsp_if.source rsp
);
  import dst_pkg::*;

  localparam int SI = $clog2(SLOTS);
  localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam logic [SLOTS-1:0] ONE = SLOTS'(1);

  state_t            state, state_next;
  opcode_t           op;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] slot_high_q;
  logic [HW-1:0]     handle_q;
  logic              ce_q;

  logic [SLOTS-1:0]  slot_valid, slot_valid_next;
  logic [SLOTS-1:0]  exec_marks, exec_marks_next;
  logic [SLOTS-1:0]  pending, pending_next;
  logic [SI-1:0]     cur, cur_next;
  res_t              res, res_next;
  res_t              obuf;
  logic              ov;

  logic              rd_en, wr_en;
  logic [SI-1:0]     rd_addr, wr_addr;
  logic [HW-1:0]     wr_data, rd_data;

  logic [SLOTS-1:0]  range_m, floor_m;
  logic [SI-1:0]     ff_idx;
  logic              ff_any;
  logic              slot_ok, slot_live, walk, out_free;
  logic [SI-1:0]     sidx;
  logic [SLOTS-1:0]  sbit, cbit, fbit;

  dst_handle_ram #(
    .DEPTH(SLOTS),
    .WIDTH(HW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // per-slot range and floor masks
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      range_m[i] = (16'(i) >= slot_q) && (16'(i) <= slot_high_q);
      floor_m[i] = 16'(i) >= slot_q;
    end
  end

  // lowest pending slot
  always_comb begin
    ff_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        ff_idx = SI'(i);
      end
    end
    ff_any = |pending;
  end

  assign slot_ok   = slot_q < 16'(SLOTS);
  assign sidx      = slot_q[SI-1:0];
  assign slot_live = slot_ok && slot_valid[sidx];
  assign sbit      = ONE << sidx;
  assign cbit      = ONE << cur;
  assign fbit      = ONE << ff_idx;
  assign walk      = (op == OP_REMOVE_RANGE) || (op == OP_EXEC_CLOSE);
  assign out_free  = !ov || rsp.ready;

  assign req.ready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (op) inside
          OP_INS_LOWEST, OP_REMOVE_RANGE, OP_EXEC_CLOSE: state_next = ST_FIND;
          OP_INS_AT:            state_next = slot_ok ? ST_READ : ST_EMIT;
          OP_REMOVE, OP_LOOKUP: state_next = slot_live ? ST_READ : ST_EMIT;
          default:              state_next = ST_EMIT;
        endcase
      end
      ST_FIND: begin
        if (op == OP_INS_LOWEST || !ff_any) state_next = ST_EMIT;
        else state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = (walk && pending != '0) ? ST_FIND : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    slot_valid_next = slot_valid;
    exec_marks_next = exec_marks;
    pending_next    = pending;
    cur_next        = cur;
    res_next        = res;
    rd_en           = 1'b0;
    rd_addr         = sidx;
    wr_en           = 1'b0;
    wr_addr         = cur;
    wr_data         = handle_q;
    unique case (state)
      ST_IDLE: ;
      ST_DECODE: begin
        res_next      = '0;
        res_next.last = 1'b1;
        cur_next      = sidx;
        unique case (op) inside
          OP_INS_LOWEST:   pending_next = ~slot_valid & floor_m;
          OP_REMOVE_RANGE: pending_next = range_m & slot_valid;
          OP_EXEC_CLOSE:   pending_next = exec_marks & slot_valid;
          OP_INS_AT: begin
            if (slot_ok) rd_en = 1'b1;
            else res_next.status = STAT_FULL;
          end
          OP_REMOVE, OP_LOOKUP: begin
            if (slot_live) rd_en = 1'b1;
            else res_next.status = STAT_BAD;
          end
          OP_MARK_RANGE: exec_marks_next = exec_marks | (range_m & slot_valid);
          OP_MARK, OP_UNMARK, OP_TEST: begin
            if (slot_live) begin
              res_next.slot_out = SLOT_OUT_W'(sidx);
              if (op == OP_MARK) exec_marks_next = exec_marks | sbit;
              if (op == OP_UNMARK) exec_marks_next = exec_marks & ~sbit;
              if (op == OP_TEST) res_next.mark_out = exec_marks[sidx];
            end else begin
              res_next.status = STAT_BAD;
            end
          end
          default: res_next.status = STAT_BAD;
        endcase
      end
      ST_FIND: begin
        res_next = '0;
        cur_next = ff_idx;
        if (op == OP_INS_LOWEST) begin
          res_next.last = 1'b1;
          if (ff_any) begin
            wr_en             = 1'b1;
            wr_addr           = ff_idx;
            slot_valid_next   = slot_valid | fbit;
            exec_marks_next   = ce_q ? (exec_marks | fbit) : (exec_marks & ~fbit);
            res_next.slot_out = SLOT_OUT_W'(ff_idx);
          end else begin
            res_next.status = STAT_FULL;
          end
        end else if (ff_any) begin
          rd_en        = 1'b1;
          rd_addr      = ff_idx;
          pending_next = pending & ~fbit;
        end else begin
          res_next.last = 1'b1;
        end
      end
      ST_READ: begin
        res_next          = '0;
        res_next.last     = 1'b1;
        res_next.slot_out = SLOT_OUT_W'(cur);
        if (op == OP_INS_AT) begin
          if (slot_valid[cur]) begin
            res_next.handle_out   = HANDLE_W'(rd_data);
            res_next.handle_valid = 1'b1;
            res_next.released     = 1'b1;
          end
          wr_en           = 1'b1;
          slot_valid_next = slot_valid | cbit;
          if (ce_q) exec_marks_next = exec_marks | cbit;
        end else begin
          // remove, lookup and walk steps all report the stored handle
          res_next.handle_out   = HANDLE_W'(rd_data);
          res_next.handle_valid = 1'b1;
          if (op != OP_LOOKUP) begin
            res_next.released = 1'b1;
            slot_valid_next   = slot_valid & ~cbit;
            exec_marks_next   = exec_marks & ~cbit;
          end
          if (walk) res_next.last = (pending == '0);
        end
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      exec_marks <= '0;
      ov         <= 1'b0;
    end else begin
      state      <= state_next;
      slot_valid <= slot_valid_next;
      exec_marks <= exec_marks_next;
      if (state == ST_EMIT && out_free) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pending <= pending_next;
    cur     <= cur_next;
    res     <= res_next;
    if (req.valid && req.ready) begin
      op          <= opcode_t'(req.opcode);
      slot_q      <= req.slot;
      slot_high_q <= req.slot_high;
      handle_q    <= req.handle[HW-1:0];
      ce_q        <= req.close_on_exec;
    end
    if (state == ST_EMIT && out_free) begin
      obuf <= res;
    end
  end

  // output word
  assign rsp.valid        = ov;
  assign rsp.status       = obuf.status;
  assign rsp.slot_out     = obuf.slot_out;
  assign rsp.handle_out   = obuf.handle_out;
  assign rsp.handle_valid = obuf.handle_valid;
  assign rsp.released     = obuf.released;
  assign rsp.mark_out     = obuf.mark_out;
  assign rsp.last         = obuf.last;

  // a mark never sits on an empty slot
  a_marks_valid: assert property (@(posedge clk) disable iff (rst)
    (exec_marks & ~slot_valid) == '0)
    else $error("close-on-exec mark on an empty slot");

  // a ram read result is only consumed right after a read was issued
  a_read_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> $past(state) == ST_DECODE || $past(state) == ST_FIND)
    else $error("read state entered without a preceding ram read");

  // during a walk, last is flagged exactly when no slot is left pending
  a_walk_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && walk) |-> ((pending == '0) == res.last))
    else $error("walk last flag disagrees with pending mask");

  // the sequencer leaves idle only on an accepted word
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !req.valid) |=> state == ST_IDLE)
    else $error("sequencer started without a request");

endmodule

// File: tb/descriptor_slot_table_core_test.sv
// self-checking testbench of the descriptor slot table core
module descriptor_slot_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dst_pkg::*;

  localparam int TBL_SLOTS    = 64;
  localparam int RANDOM_WORDS = 380;
  localparam int TRAIL_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   slot;
    logic [SLOT_W-1:0]   slot_high;
    logic [HANDLE_W-1:0] handle;
    logic                close_on_exec;
  } op_word_t;

  logic clk;
  logic rst;

  dst_req_if req();
  dst_rsp_if rsp();

  descriptor_slot_table_core #(
    .SLOTS(TBL_SLOTS),
    .HANDLE_BITS(HANDLE_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // words waiting to be sent and result words still owed by the block
  op_word_t op_words[$];
  res_t     due_results[$];

  // predicted contents of the slot table
  logic [HANDLE_W-1:0]  table_handles[TBL_SLOTS];
  logic [TBL_SLOTS-1:0] table_valid;
  logic [TBL_SLOTS-1:0] table_marks;

  int   mismatches;
  int   quiet_cycles;
  bit   word_taken;
  int   burst_left;
  int   gap_left;
  int   pat_cycles;
  logic [15:0] ready_pat;

  // slots lo..hi with hi clamped to the last slot
  function automatic logic [TBL_SLOTS-1:0] span_mask(input int unsigned lo,
                                                     input int unsigned hi);
    logic [TBL_SLOTS-1:0] m;
    int i;
    m = '0;
    if (hi > TBL_SLOTS - 1) hi = TBL_SLOTS - 1;
    for (i = 0; i < TBL_SLOTS; i++) begin
      if (i >= lo && i <= hi) m[i] = 1'b1;
    end
    return m;
  endfunction

  // release the valid slots of sel, one result word each in rising order
  function automatic void release_slots(input logic [TBL_SLOTS-1:0] sel);
    res_t r;
    int   total;
    int   k;
    int   i;
    sel = sel & table_valid;
    total = $countones(sel);
    k = 0;
    for (i = 0; i < TBL_SLOTS; i++) begin
      if (sel[i]) begin
        k++;
        r = '0;
        r.status = STAT_OK;
        r.slot_out = SLOT_OUT_W'(i);
        r.handle_out = table_handles[i];
        r.handle_valid = 1'b1;
        r.released = 1'b1;
        r.last = (k == total);
        due_results.push_back(r);
      end
    end
    table_valid = table_valid & ~sel;
    table_marks = table_marks & ~sel;
    if (total == 0) begin
      r = '0;
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endfunction

  // update the table for one accepted word and queue the words it owes
  function automatic void apply_table_op(input op_word_t w);
    res_t r;
    int unsigned lo;
    int unsigned hi;
    int i;
    bit single;
    r = '0;
    r.last = 1'b1;
    lo = 32'(w.slot);
    hi = 32'(w.slot_high);
    single = 1'b1;
    case (w.opcode)
      OP_INS_LOWEST: begin
        r.status = STAT_FULL;
        for (i = lo; i < TBL_SLOTS; i++) begin
          if (!table_valid[i] && r.status == STAT_FULL) begin
            r.status = STAT_OK;
            r.slot_out = SLOT_OUT_W'(i);
            table_handles[i] = w.handle;
            table_valid[i] = 1'b1;
            table_marks[i] = w.close_on_exec;
          end
        end
      end
      OP_INS_AT: begin
        if (lo >= TBL_SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          r.slot_out = SLOT_OUT_W'(lo);
          // an occupied slot hands back its old handle
          if (table_valid[lo]) begin
            r.handle_out = table_handles[lo];
            r.handle_valid = 1'b1;
            r.released = 1'b1;
          end
          table_handles[lo] = w.handle;
          table_valid[lo] = 1'b1;
          if (w.close_on_exec) table_marks[lo] = 1'b1;
        end
      end
      OP_REMOVE_RANGE: begin
        release_slots(span_mask(lo, hi));
        single = 1'b0;
      end
      OP_MARK_RANGE: begin
        table_marks = table_marks | (span_mask(lo, hi) & table_valid);
      end
      OP_EXEC_CLOSE: begin
        release_slots(table_marks);
        single = 1'b0;
      end
      default: begin
        // single-slot operations need an open descriptor
        if (w.opcode > OP_EXEC_CLOSE || lo >= TBL_SLOTS || !table_valid[lo]) begin
          r.status = STAT_BAD;
        end else begin
          r.slot_out = SLOT_OUT_W'(lo);
          case (w.opcode)
            OP_REMOVE: begin
              r.handle_out = table_handles[lo];
              r.handle_valid = 1'b1;
              r.released = 1'b1;
              table_valid[lo] = 1'b0;
              table_marks[lo] = 1'b0;
            end
            OP_LOOKUP: begin
              r.handle_out = table_handles[lo];
              r.handle_valid = 1'b1;
            end
            OP_MARK: table_marks[lo] = 1'b1;
            OP_UNMARK: table_marks[lo] = 1'b0;
            default: r.mark_out = table_marks[lo];
          endcase
        end
      end
    endcase
    if (single) due_results.push_back(r);
  endfunction

  function automatic void add_word(input logic [OPCODE_W-1:0] op,
                                   input logic [SLOT_W-1:0] lo,
                                   input logic [SLOT_W-1:0] hi,
                                   input logic [HANDLE_W-1:0] h,
                                   input logic coe);
    op_word_t w;
    w.opcode = op;
    w.slot = lo;
    w.slot_high = hi;
    w.handle = h;
    w.close_on_exec = coe;
    op_words.push_back(w);
  endfunction

  // slot index, mostly inside the table, sometimes far beyond it
  function automatic logic [SLOT_W-1:0] pick_slot();
    case ($urandom_range(0, 9))
      0: return SLOT_W'($urandom);
      1: return SLOT_W'($urandom_range(64, 65535));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return SLOT_W'(TBL_SLOTS - 1);
          2: return SLOT_W'(TBL_SLOTS);
          default: return '1;
        endcase
      end
      3, 4, 5: return SLOT_W'($urandom_range(0, 15));
      default: return SLOT_W'($urandom_range(0, TBL_SLOTS - 1));
    endcase
  endfunction

  // range high end: wide, narrow, below the low end or beyond the table
  function automatic logic [SLOT_W-1:0] pick_high(input logic [SLOT_W-1:0] lo);
    case ($urandom_range(0, 4))
      0: return '1;
      1: return SLOT_W'($urandom);
      2: return lo + SLOT_W'($urandom_range(0, 6));
      3: return SLOT_W'($urandom_range(0, TBL_SLOTS - 1));
      default: return lo + SLOT_W'($urandom_range(0, 20));
    endcase
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return HANDLE_W'($urandom);
    endcase
  endfunction

  // one word of the mixed traffic
  function automatic op_word_t random_word();
    op_word_t w;
    int p;
    p = $urandom_range(0, 99);
    w.slot = pick_slot();
    w.slot_high = SLOT_W'($urandom);
    w.handle = pick_handle();
    w.close_on_exec = 1'($urandom_range(0, 1));
    if (p < 20) begin
      w.opcode = OP_INS_LOWEST;
      if ($urandom_range(0, 1) == 0) w.slot = '0;
    end else if (p < 32) w.opcode = OP_INS_AT;
    else if (p < 44) w.opcode = OP_REMOVE;
    else if (p < 54) w.opcode = OP_LOOKUP;
    else if (p < 60) w.opcode = OP_REMOVE_RANGE;
    else if (p < 66) w.opcode = OP_MARK_RANGE;
    else if (p < 74) w.opcode = OP_MARK;
    else if (p < 80) w.opcode = OP_UNMARK;
    else if (p < 90) w.opcode = OP_TEST;
    else if (p < 95) w.opcode = OP_EXEC_CLOSE;
    else w.opcode = OPCODE_W'($urandom_range(10, 15));
    if (w.opcode == OP_REMOVE_RANGE || w.opcode == OP_MARK_RANGE)
      w.slot_high = pick_high(w.slot);
    return w;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset and known levels on every input
  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.opcode = '0;
    req.slot = '0;
    req.slot_high = '0;
    req.handle = '0;
    req.close_on_exec = 1'b0;
    rsp.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // stimulus and end of run
  initial begin
    int made;
    int cnt;
    int kind;
    int j;
    op_word_t w;
    mismatches = 0;
    table_valid = '0;
    table_marks = '0;

    // directed: empty table, extremes, replacement, marks, bad opcodes
    add_word(OP_LOOKUP, '0, '0, '0, 1'b0);
    add_word(OP_REMOVE, '1, '0, '0, 1'b0);
    add_word(OP_EXEC_CLOSE, '0, '0, '0, 1'b0);
    add_word(OP_REMOVE_RANGE, '0, '1, '0, 1'b0);
    add_word(OP_INS_LOWEST, '0, '0, '1, 1'b1);
    add_word(OP_INS_LOWEST, '0, '1, '0, 1'b0);
    add_word(OP_INS_LOWEST, 16'd63, '0, 16'hA5A5, 1'b1);
    add_word(OP_INS_LOWEST, 16'd64, '0, 16'h1234, 1'b1);
    add_word(OP_INS_LOWEST, '1, '0, 16'h4321, 1'b0);
    add_word(OP_INS_AT, 16'd64, '0, 16'h0F0F, 1'b1);
    add_word(OP_INS_AT, 16'd1, '0, 16'h5A5A, 1'b0);
    add_word(OP_INS_AT, 16'd5, '0, 16'h8001, 1'b1);
    add_word(OP_INS_AT, 16'd0, '0, 16'h7FFE, 1'b0);
    add_word(OP_LOOKUP, 16'd63, '0, '0, 1'b0);
    add_word(OP_TEST, 16'd0, '0, '0, 1'b0);
    add_word(OP_MARK, 16'd1, '0, '0, 1'b0);
    add_word(OP_UNMARK, 16'd5, '0, '0, 1'b0);
    add_word(OP_TEST, 16'd5, '0, '0, 1'b0);
    add_word(OP_MARK_RANGE, 16'd2, '1, '0, 1'b0);
    add_word(OP_MARK_RANGE, 16'd40, 16'd3, '0, 1'b0);
    add_word(OP_REMOVE_RANGE, 16'd60, 16'd62, '0, 1'b0);
    add_word(OP_REMOVE_RANGE, 16'd40, '1, '0, 1'b0);
    add_word(4'd10, 16'd0, '0, '0, 1'b0);
    add_word(4'd15, '1, '1, '1, 1'b1);
    add_word(OP_EXEC_CLOSE, '0, '0, '0, 1'b0);
    add_word(OP_REMOVE, 16'd0, '0, '0, 1'b0);

    // random rounds: filling the table, bulk releases, mixed traffic
    made = 0;
    kind = 0;
    while (made < RANDOM_WORDS) begin
      if (kind == 0) begin
        cnt = $urandom_range(60, 72);
        for (j = 0; j < cnt; j++)
          add_word(OP_INS_LOWEST, ($urandom_range(0, 7) == 0) ? pick_slot() : '0,
                   SLOT_W'($urandom), pick_handle(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1) == 0) begin
          add_word(OP_MARK_RANGE, '0, '1, '0, 1'b0);
          add_word(OP_EXEC_CLOSE, '0, '0, '0, 1'b0);
        end else begin
          add_word(OP_REMOVE_RANGE, SLOT_W'($urandom_range(0, 8)), pick_high('0), '0,
                   1'b0);
        end
        made += cnt + 2;
      end else if (kind == 1) begin
        w.slot = pick_slot();
        add_word(OP_MARK_RANGE, w.slot, pick_high(w.slot), '0, 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          add_word(OP_EXEC_CLOSE, '0, '0, '0, 1'b0);
        end else begin
          w.slot = pick_slot();
          add_word(OP_REMOVE_RANGE, w.slot, pick_high(w.slot), '0, 1'b0);
        end
        made += 2;
      end else begin
        cnt = $urandom_range(20, 40);
        for (j = 0; j < cnt; j++) op_words.push_back(random_word());
        made += cnt;
      end
      kind = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 1) : 2;
    end

    // wait for the last word to go in and every owed result to come back
    @(negedge rst);
    while (op_words.size() != 0 || req.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TRAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // request driver: bursts of words separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!req.valid || word_taken) begin
      if (gap_left > 0) begin
        req.valid <= 1'b0;
        gap_left--;
      end else if (op_words.size() != 0) begin
        req.opcode <= op_words[0].opcode;
        req.slot <= op_words[0].slot;
        req.slot_high <= op_words[0].slot_high;
        req.handle <= op_words[0].handle;
        req.close_on_exec <= op_words[0].close_on_exec;
        req.valid <= 1'b1;
        void'(op_words.pop_front());
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // response ready: rotating stall pattern, reloaded now and then
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      pat_cycles = 0;
      ready_pat = '1;
    end else begin
      if (pat_cycles == 0) begin
        pat_cycles = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: ready_pat = '1;
          1: ready_pat = 16'($urandom);
          2: ready_pat = 16'($urandom | $urandom);
          default: ready_pat = 16'($urandom & $urandom);
        endcase
        // at least one open cycle per turn of the pattern
        ready_pat[$urandom_range(0, 15)] = 1'b1;
      end
      rsp.ready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
      pat_cycles--;
    end
  end

  // monitor: predict on each accepted word, check each result word
  always @(posedge clk) begin
    op_word_t w;
    res_t got;
    res_t want;
    word_taken = 1'b0;
    if (!rst) begin
      if (req.valid && req.ready) begin
        word_taken = 1'b1;
        w.opcode = req.opcode;
        w.slot = req.slot;
        w.slot_high = req.slot_high;
        w.handle = req.handle;
        w.close_on_exec = req.close_on_exec;
        apply_table_op(w);
      end
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.slot_out = rsp.slot_out;
        got.handle_out = rsp.handle_out;
        got.handle_valid = rsp.handle_valid;
        got.released = rsp.released;
        got.mark_out = rsp.mark_out;
        got.last = rsp.last;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result word: st=%0d slot=%0d h=%h hv=%b rel=%b mk=%b last=%b",
                     got.status, got.slot_out, got.handle_out, got.handle_valid,
                     got.released, got.mark_out, got.last);
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.slot_out !== want.slot_out ||
              got.handle_out !== want.handle_out ||
              got.handle_valid !== want.handle_valid ||
              got.released !== want.released || got.mark_out !== want.mark_out ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("result mismatch: exp st=%0d slot=%0d h=%h hv=%b rel=%b mk=%b last=%b",
                       want.status, want.slot_out, want.handle_out, want.handle_valid,
                       want.released, want.mark_out, want.last);
              $display("                 got st=%0d slot=%0d h=%h hv=%b rel=%b mk=%b last=%b",
                       got.status, got.slot_out, got.handle_out, got.handle_valid,
                       got.released, got.mark_out, got.last);
            end
          end
        end
      end
    end
  end

  // watchdog: too long with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: descriptor_slot_table_core.f
hw/rtl/dst_pkg.sv
hw/rtl/dst_req_if.sv
hw/rtl/dst_rsp_if.sv
hw/rtl/dst_handle_ram.sv
hw/rtl/descriptor_slot_table_core.sv
tb/descriptor_slot_table_core_test.sv
